/* design/psd_pkg.sv */
// Package: widths, stage word types and projection modes for the point-segment distance block.
`default_nettype none
package psd_pkg;

  localparam int COORD_BITS = 14;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 45;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int LEN_W  = 2 * DIFF_W - 1;
  localparam int DOT_W  = PROD_W + 1;
  localparam int T_W    = FRAC_BITS + 1;
  localparam int OFF_W  = T_W + DIFF_W + 1;
  localparam int MAG_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int EXT_W  = (SUM_W > OUT_BITS) ? SUM_W : OUT_BITS;

  typedef enum logic [1:0] {
    T_ZERO,
    T_ONE,
    T_DIV
  } mode_e;

  typedef struct packed {
    mode_e                   mode;
    logic [LEN_W-1:0]        rem;
    logic [LEN_W-1:0]        len2;
    logic [FRAC_BITS-1:0]    q;
    logic signed [DIFF_W-1:0] pqx;
    logic signed [DIFF_W-1:0] pqy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } div_t;

endpackage
`default_nettype wire

/* design/psd_front.sv */
// Front stages: coordinate differences, products, length and dot sums, mode select.
`default_nettype none
module psd_front
  import psd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] seg_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output div_t                         out_data_o
);

  logic                     v_a_q, v_b_q, v_c_q;
  logic                     en_a, en_b, en_c;
  logic signed [DIFF_W-1:0] pqx_a_q, pqy_a_q, dx_a_q, dy_a_q;
  logic signed [DIFF_W-1:0] pqx_b_q, pqy_b_q, dx_b_q, dy_b_q;
  logic signed [PROD_W-1:0] pxx_q, pyy_q, pxd_q, pyd_q;
  logic [LEN_W-1:0]         len2;
  logic signed [DOT_W-1:0]  dot;
  div_t                     data_d, data_q;

  assign en_c       = !v_c_q || out_ready_i;
  assign en_b       = !v_b_q || en_c;
  assign en_a       = !v_a_q || en_b;
  assign in_ready_o = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
    end else begin
      if (en_a) v_a_q <= in_valid_i;
      if (en_b) v_b_q <= v_a_q;
      if (en_c) v_c_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      pqx_a_q <= DIFF_W'(seg_end_x_i) - DIFF_W'(seg_start_x_i);
      pqy_a_q <= DIFF_W'(seg_end_y_i) - DIFF_W'(seg_start_y_i);
      dx_a_q  <= DIFF_W'(point_x_i) - DIFF_W'(seg_start_x_i);
      dy_a_q  <= DIFF_W'(point_y_i) - DIFF_W'(seg_start_y_i);
    end
    if (en_b) begin
      pxx_q   <= pqx_a_q * pqx_a_q;
      pyy_q   <= pqy_a_q * pqy_a_q;
      pxd_q   <= pqx_a_q * dx_a_q;
      pyd_q   <= pqy_a_q * dy_a_q;
      pqx_b_q <= pqx_a_q;
      pqy_b_q <= pqy_a_q;
      dx_b_q  <= dx_a_q;
      dy_b_q  <= dy_a_q;
    end
    if (en_c) data_q <= data_d;
  end

  always_comb begin
    len2 = LEN_W'(pxx_q[PROD_W-2:0]) + LEN_W'(pyy_q[PROD_W-2:0]);
    dot  = DOT_W'(pxd_q) + DOT_W'(pyd_q);
    data_d.len2 = len2;
    data_d.rem  = dot[LEN_W-1:0];
    data_d.q    = '0;
    data_d.pqx  = pqx_b_q;
    data_d.pqy  = pqy_b_q;
    data_d.dx   = dx_b_q;
    data_d.dy   = dy_b_q;
    if (len2 == '0 || dot <= 0) begin
      data_d.mode = T_ZERO;
    end else if (dot >= $signed({1'b0, len2, 1'b0}) >>> 1) begin
      data_d.mode = T_ONE;
    end else begin
      data_d.mode = T_DIV;
    end
  end

  assign out_valid_o = v_c_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

/* design/psd_div_cell.sv */
// Divider cell: one restoring step, one quotient bit per word.
`default_nettype none
module psd_div_cell
  import psd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  div_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output div_t out_data_o
);

  logic           v_q;
  logic           en;
  logic [LEN_W:0] rem2;
  logic           qbit;
  div_t           data_d, data_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    rem2   = {in_data_i.rem, 1'b0};
    qbit   = (rem2 >= {1'b0, in_data_i.len2});
    data_d = in_data_i;
    data_d.q = FRAC_BITS'({in_data_i.q, qbit});
    if (qbit) begin
      data_d.rem = LEN_W'(rem2 - {1'b0, in_data_i.len2});
    end else begin
      data_d.rem = rem2[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) data_q <= data_d;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

/* design/psd_back.sv */
// Back stages: clamped projection, offsets, squares and scaled sum.
`default_nettype none
module psd_back
  import psd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  div_t                in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OUT_BITS-1:0] dist_sq_o
);

  logic                       v_d_q, v_e_q, v_f_q;
  logic                       en_d, en_e, en_f;
  logic [T_W-1:0]             t;
  logic signed [T_W+DIFF_W:0] tpx, tpy;
  logic signed [OFF_W-1:0]    ox_q, oy_q;
  logic [OFF_W-1:0]           ax_full, ay_full;
  logic [MAG_W-1:0]           ax, ay;
  logic [SQ_W-1:0]            asq_q, bsq_q;
  logic [EXT_W-1:0]           ext;
  logic [OUT_BITS-1:0]        dist_q;

  assign en_f       = !v_f_q || out_ready_i;
  assign en_e       = !v_e_q || en_f;
  assign en_d       = !v_d_q || en_e;
  assign in_ready_o = en_d;

  always_comb begin
    case (in_data_i.mode)
      T_ONE:   t = T_W'(1) << FRAC_BITS;
      T_DIV:   t = T_W'(in_data_i.q);
      default: t = '0;
    endcase
    tpx = $signed({1'b0, t}) * in_data_i.pqx;
    tpy = $signed({1'b0, t}) * in_data_i.pqy;
    ax_full = ox_q[OFF_W-1] ? OFF_W'(-ox_q) : OFF_W'(ox_q);
    ay_full = oy_q[OFF_W-1] ? OFF_W'(-oy_q) : OFF_W'(oy_q);
    ax = ax_full[MAG_W-1:0];
    ay = ay_full[MAG_W-1:0];
    ext = EXT_W'((SUM_W'(asq_q) + SUM_W'(bsq_q)) >> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
      v_f_q <= 1'b0;
    end else begin
      if (en_d) v_d_q <= in_valid_i;
      if (en_e) v_e_q <= v_d_q;
      if (en_f) v_f_q <= v_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      ox_q <= OFF_W'(tpx) - OFF_W'($signed({in_data_i.dx, {FRAC_BITS{1'b0}}}));
      oy_q <= OFF_W'(tpy) - OFF_W'($signed({in_data_i.dy, {FRAC_BITS{1'b0}}}));
    end
    if (en_e) begin
      asq_q <= ax * ax;
      bsq_q <= ay * ay;
    end
    if (en_f) dist_q <= ext[OUT_BITS-1:0];
  end

  assign out_valid_o = v_f_q;
  assign dist_sq_o   = dist_q;

endmodule
`default_nettype wire

/* design/point_segment_distance_sq_top.sv */
// Top level: squared distance from a point to a segment, fully pipelined.
// Stages: 3 front, 16 divider cells and 3 back between accepted word and result,
//   one quotient bit per divider cell.
// Throughput: one word per cycle; each stage holds while its successor is stalled,
//   so empty stages fill while a result waits.
// Reset: rst_ni clears every stage valid bit asynchronously; data registers are not reset.
`default_nettype none
module point_segment_distance_sq_top
  import psd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] seg_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [OUT_BITS-1:0]          dist_sq_o
);

  logic in_ready;
  logic chain_valid [FRAC_BITS+1];
  logic chain_ready [FRAC_BITS+1];
  div_t chain_data  [FRAC_BITS+1];

  assign in_stall_o = !in_ready;

  psd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .seg_start_x_i (seg_start_x_i),
    .seg_start_y_i (seg_start_y_i),
    .seg_end_x_i   (seg_end_x_i),
    .seg_end_y_i   (seg_end_y_i),
    .out_valid_o   (chain_valid[0]),
    .out_ready_i   (chain_ready[0]),
    .out_data_o    (chain_data[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    psd_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[i]),
      .in_ready_o  (chain_ready[i]),
      .in_data_i   (chain_data[i]),
      .out_valid_o (chain_valid[i+1]),
      .out_ready_i (chain_ready[i+1]),
      .out_data_o  (chain_data[i+1])
    );
  end

  psd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[FRAC_BITS]),
    .in_ready_o  (chain_ready[FRAC_BITS]),
    .in_data_i   (chain_data[FRAC_BITS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .dist_sq_o   (dist_sq_o)
  );

  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_front_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[0] && chain_data[0].mode == T_DIV |-> chain_data[0].rem < chain_data[0].len2)
    else $error("divider entry remainder not below divisor");

  a_last_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[FRAC_BITS] && chain_data[FRAC_BITS].mode == T_DIV
      |-> chain_data[FRAC_BITS].rem < chain_data[FRAC_BITS].len2)
    else $error("divider exit remainder not below divisor");

  a_accept_fills_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i |=> out_stall_i || !in_stall_o)
    else $error("pipeline blocked after accept with free output");

endmodule
`default_nettype wire

/* bench/psd_checker.sv */
// Checker: watches both channels, predicts each squared distance and compares results in order.
`default_nettype none
module psd_checker
  import psd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] seg_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg_end_y_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [OUT_BITS-1:0]          dist_sq_i,
  output int                           mismatch_count_o,
  output int                           pending_o,
  output int                           checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [OUT_BITS-1:0] dist_q[$];

  function automatic logic [OUT_BITS-1:0] seg_dist_sq(
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic signed [COORD_BITS-1:0] sx,
    input logic signed [COORD_BITS-1:0] sy,
    input logic signed [COORD_BITS-1:0] ex,
    input logic signed [COORD_BITS-1:0] ey
  );
    longint pqx, pqy, dx, dy, len2, proj, unit, t, ox, oy;
    longint unsigned a, b, fmask, sum;
    pqx  = longint'(ex) - longint'(sx);
    pqy  = longint'(ey) - longint'(sy);
    dx   = longint'(px) - longint'(sx);
    dy   = longint'(py) - longint'(sy);
    len2 = pqx * pqx + pqy * pqy;
    proj = pqx * dx + pqy * dy;
    unit = longint'(1) << FRAC_BITS;
    if (len2 == 0 || proj <= 0) begin
      t = 0;
    end else if (proj >= len2) begin
      t = unit;
    end else begin
      t = longint'((longint'(unsigned'(proj)) << FRAC_BITS) / len2);
    end
    ox    = t * pqx - dx * unit;
    oy    = t * pqy - dy * unit;
    a     = (ox < 0) ? longint'(unsigned'(-ox)) : longint'(unsigned'(ox));
    b     = (oy < 0) ? longint'(unsigned'(-oy)) : longint'(unsigned'(oy));
    a     = a * a;
    b     = b * b;
    fmask = (64'd1 << FRAC_BITS) - 64'd1;
    sum   = (a >> FRAC_BITS) + (b >> FRAC_BITS) + (((a & fmask) + (b & fmask)) >> FRAC_BITS);
    return sum[OUT_BITS-1:0];
  endfunction

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
    checked_o        = 0;
  end

  always @(posedge clk_i) begin
    logic [OUT_BITS-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        dist_q.push_back(seg_dist_sq(point_x_i, point_y_i, seg_start_x_i, seg_start_y_i,
                                     seg_end_x_i, seg_end_y_i));
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o = checked_o + 1;
        if (dist_q.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: unexpected result dist_sq=%0d with nothing pending", $realtime,
                     dist_sq_i);
          end
          mismatch_count_o = mismatch_count_o + 1;
        end else begin
          want = dist_q.pop_front();
          if (dist_sq_i !== want) begin
            if (mismatch_count_o < 10) begin
              $display("%0t: dist_sq mismatch: expected %0d, got %0d", $realtime, want,
                       dist_sq_i);
            end
            mismatch_count_o = mismatch_count_o + 1;
          end
        end
      end
      pending_o = dist_q.size();
    end
  end

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Testbench top: drives point/segment words with random gaps and stalls, and reports the verdict.
`default_nettype none
module testbench;
  import psd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1730;
  localparam int BLOCK_WORDS  = 250;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [COORD_BITS-1:0] point_x, point_y;
  logic signed [COORD_BITS-1:0] seg_start_x, seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x, seg_end_y;
  logic                         out_valid;
  logic                         out_stall;
  logic [OUT_BITS-1:0]          dist_sq;

  int   mismatches, pending, checked;
  int   words_sent;
  bit   tx_idle, rx_idle, hold_req;

  point_segment_distance_sq_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .seg_start_x_i (seg_start_x),
    .seg_start_y_i (seg_start_y),
    .seg_end_x_i   (seg_end_x),
    .seg_end_y_i   (seg_end_y),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .dist_sq_o     (dist_sq)
  );

  psd_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .point_x_i        (point_x),
    .point_y_i        (point_y),
    .seg_start_x_i    (seg_start_x),
    .seg_start_y_i    (seg_start_y),
    .seg_end_x_i      (seg_end_x),
    .seg_end_y_i      (seg_end_y),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .dist_sq_i        (dist_sq),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [COORD_BITS-1:0] any_coord();
    return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
  endfunction

  function automatic logic signed [COORD_BITS-1:0] small_coord();
    return COORD_BITS'($signed($urandom_range(0, 31)) - 16);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] edge_coord();
    case ($urandom_range(0, 5))
      0:       return -14'sd8192;
      1:       return -14'sd8191;
      2:       return -14'sd1;
      3:       return 14'sd0;
      4:       return 14'sd1;
      default: return 14'sd8191;
    endcase
  endfunction

  task automatic send_word(
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic signed [COORD_BITS-1:0] sx,
    input logic signed [COORD_BITS-1:0] sy,
    input logic signed [COORD_BITS-1:0] ex,
    input logic signed [COORD_BITS-1:0] ey
  );
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_x     <= px;
    point_y     <= py;
    seg_start_x <= sx;
    seg_start_y <= sy;
    seg_end_x   <= ex;
    seg_end_y   <= ey;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_word();
    logic signed [COORD_BITS-1:0] px, py, sx, sy, ex, ey;
    int pick;
    pick = $urandom_range(0, 99);
    sx = any_coord();
    sy = any_coord();
    ex = any_coord();
    ey = any_coord();
    px = any_coord();
    py = any_coord();
    if (pick < 40) begin
    end else if (pick < 58) begin
      sx = small_coord();
      sy = small_coord();
      ex = small_coord();
      ey = small_coord();
      px = small_coord();
      py = small_coord();
    end else if (pick < 68) begin
      ex = sx;
      ey = sy;
    end else if (pick < 80) begin
      sx = edge_coord();
      sy = edge_coord();
      ex = edge_coord();
      ey = edge_coord();
      px = edge_coord();
      py = edge_coord();
    end else if (pick < 90) begin
      if ($urandom_range(0, 1)) begin
        px = sx + small_coord();
        py = sy + small_coord();
      end else begin
        px = ex + small_coord();
        py = ey + small_coord();
      end
    end else begin
      ex = sx + small_coord();
      ey = sy + small_coord();
    end
    send_word(px, py, sx, sy, ex, ey);
  endtask

  // receiver: random stall before each result while rx_idle is set, one long hold-off on request
  initial begin
    int wait_cycles;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        wait_cycles = HOLD_CYCLES;
      end else begin
        wait_cycles = rx_idle ? $urandom_range(0, 11) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog: no word moved for %0d cycles, %0d results pending", IDLE_LIMIT,
             pending);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    point_x     = '0;
    point_y     = '0;
    seg_start_x = '0;
    seg_start_y = '0;
    seg_end_x   = '0;
    seg_end_y   = '0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    hold_req    = 1'b0;
    words_sent  = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    send_word(14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 14'sd0);
    send_word(-14'sd8192, -14'sd8192, -14'sd8192, -14'sd8192, -14'sd8192, -14'sd8192);
    send_word(14'sd8191, 14'sd8191, 14'sd8191, 14'sd8191, 14'sd8191, 14'sd8191);
    send_word(14'sd8191, 14'sd8191, -14'sd8192, -14'sd8192, -14'sd8192, -14'sd8192);
    send_word(-14'sd8192, -14'sd8192, 14'sd8191, 14'sd8191, 14'sd8191, 14'sd8191);
    send_word(14'sd8191, -14'sd8192, -14'sd8192, -14'sd8192, 14'sd8191, 14'sd8191);
    send_word(-14'sd8192, -14'sd8192, -14'sd8192, 14'sd8191, 14'sd8191, -14'sd8192);
    send_word(14'sd8191, -14'sd8192, -14'sd8192, 14'sd8191, -14'sd8192, 14'sd8191);
    send_word(14'sd0, 14'sd0, 14'sd8191, -14'sd8192, -14'sd8192, 14'sd8191);
    send_word(-14'sd50, 14'sd30, 14'sd0, 14'sd0, 14'sd100, 14'sd0);
    send_word(14'sd150, -14'sd30, 14'sd0, 14'sd0, 14'sd100, 14'sd0);
    send_word(14'sd37, 14'sd25, 14'sd0, 14'sd0, 14'sd100, 14'sd0);
    send_word(14'sd100, 14'sd77, 14'sd0, 14'sd0, 14'sd100, 14'sd0);
    send_word(14'sd0, 14'sd55, 14'sd0, 14'sd0, 14'sd100, 14'sd0);
    send_word(14'sd3, 14'sd3, -14'sd3, -14'sd3, 14'sd9, 14'sd9);
    send_word(14'sd1, 14'sd5, 14'sd0, 14'sd0, 14'sd3, 14'sd0);
    send_word(-14'sd8192, 14'sd8191, 14'sd0, 14'sd0, 14'sd1, 14'sd0);
    send_word(14'sd8191, 14'sd8191, -14'sd8192, -14'sd8192, -14'sd8191, -14'sd8192);
    send_word(-14'sd8192, 14'sd0, 14'sd5, -14'sd8192, 14'sd5, 14'sd8191);
    send_word(14'sd1, -14'sd1, -14'sd1, -14'sd1, 14'sd0, 14'sd0);

    // drain before the random part
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % BLOCK_WORDS == 0) begin
        case ((i / BLOCK_WORDS) % 4)
          0: begin tx_idle = 1'b1; rx_idle = 1'b1; end
          1: begin tx_idle = 1'b0; rx_idle = 1'b0; end
          2: begin tx_idle = 1'b0; rx_idle = 1'b1; end
          default: begin tx_idle = 1'b1; rx_idle = 1'b0; end
        endcase
        if (i == BLOCK_WORDS) hold_req = 1'b1;
      end
      if (i == 3 * BLOCK_WORDS) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send_random_word();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Summary: %0d words sent, %0d results checked; extremes, zero-length, clamped",
             words_sent, checked);
    $display("  and interior cases under random gaps, a long output hold-off and a drain pause");
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
